>>> hw/rtl/oeq_pkg.sv
package oeq_pkg;

   // queue geometry
   localparam int Capacity   = 16;
   localparam int ValueWidth = 32;

   // stored entries never exceed the 32 bit field that carries them
   localparam int StoreWidth = (ValueWidth < 32) ? ValueWidth : 32;
   localparam int CountWidth = $clog2(Capacity + 1);
   localparam int IdxWidth   = (Capacity > 1) ? $clog2(Capacity) : 1;

   // request kinds
   localparam logic [2:0] KindPush   = 3'd0;
   localparam logic [2:0] KindPop    = 3'd1;
   localparam logic [2:0] KindInsert = 3'd2;
   localparam logic [2:0] KindErase  = 3'd3;
   localparam logic [2:0] KindGet    = 3'd4;
   localparam logic [2:0] KindClear  = 3'd5;

   typedef struct packed {
      logic [2:0]  kind;
      logic [31:0] value;
      logic [3:0]  position;
   } req_type;

   typedef struct packed {
      logic        ok;
      logic [31:0] data;
      logic [4:0]  count;
   } rsp_type;

   // per-cycle command broadcast to every cell
   typedef enum logic [1:0] {
      OP_HOLD,
      OP_ADD,
      OP_REMOVE,
      OP_CLEAR
   } cell_op_type;

   typedef struct packed {
      cell_op_type           op;
      logic                  ordered;
      logic                  head;
      logic [StoreWidth-1:0] value;
   } cell_cmd_type;

endpackage

>>> hw/rtl/ordered_entry_queue.sv
// ordered_entry_queue: bounded queue of up to Capacity unsigned values held
// in a row of shift cells, head in cell 0. push appends at the tail (a zero
// value is refused), pop takes the head, ordered insert puts the value ahead
// of the first entry it is greater than or equal to, erase drops every equal
// entry, get reads the entry at a position and clear empties the queue.
// ordered insert and erase need the ordering_enabled bit, written through the
// csr channel; the user must write it only while the queue is idle, the block
// itself does not enforce this. one rsp item comes back for every req item.
// an item is registered when taken and run once the output register is free;
// no new one is taken before it is done. erase closes one gap per cycle. a
// finished result sits in the output register while the next item is taken.
module ordered_entry_queue
   import oeq_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   // request channel
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_payload,
   // response channel
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_payload,
   // ordering_enabled register write
   input  logic    csr_valid,
   output logic    csr_ready,
   input  logic    csr_data
);

   cell_cmd_type          cell_cmd;
   logic [StoreWidth-1:0] cell_value [Capacity];
   logic [Capacity-1:0]   cell_valid;
   // insert and remove chains ripple from head to tail
   logic [Capacity:0]     ins_chain;
   logic [Capacity:0]     rm_chain;

   assign ins_chain[0] = 1'b0;
   assign rm_chain[0]  = 1'b0;

   for (genvar i = 0; i < Capacity; i++) begin : g_cell
      logic [StoreWidth-1:0] left_value;
      logic                  left_valid;
      logic [StoreWidth-1:0] right_value;
      logic                  right_valid;

      // head cell has nothing to its left
      if (i == 0) begin : g_head
         assign left_value = '0;
         assign left_valid = 1'b0;
      end else begin : g_body
         assign left_value = cell_value[i-1];
         assign left_valid = cell_valid[i-1];
      end

      // tail cell pulls in an empty slot on a remove
      if (i == Capacity - 1) begin : g_tail
         assign right_value = '0;
         assign right_valid = 1'b0;
      end else begin : g_inner
         assign right_value = cell_value[i+1];
         assign right_valid = cell_valid[i+1];
      end

      oeq_cell u_cell (
         .clock       (clock),
         .reset       (reset),
         .cmd         (cell_cmd),
         .left_value  (left_value),
         .left_valid  (left_valid),
         .right_value (right_value),
         .right_valid (right_valid),
         .ins_in      (ins_chain[i]),
         .rm_in       (rm_chain[i]),
         .entry_value (cell_value[i]),
         .entry_valid (cell_valid[i]),
         .ins_out     (ins_chain[i+1]),
         .rm_out      (rm_chain[i+1])
      );
   end

   // sequencing, occupancy count, config bit and the output register
   oeq_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_data    (csr_data),
      .cell_value  (cell_value),
      .cell_valid  (cell_valid),
      .removed     (rm_chain[Capacity]),
      .cell_cmd    (cell_cmd)
   );

endmodule

>>> hw/rtl/oeq_cell.sv
module oeq_cell
   import oeq_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  cell_cmd_type          cmd,
   input  logic [StoreWidth-1:0] left_value,
   input  logic                  left_valid,
   input  logic [StoreWidth-1:0] right_value,
   input  logic                  right_valid,
   input  logic                  ins_in,
   input  logic                  rm_in,
   output logic [StoreWidth-1:0] entry_value,
   output logic                  entry_valid,
   output logic                  ins_out,
   output logic                  rm_out
);

   logic [StoreWidth-1:0] value_ff;
   logic [StoreWidth-1:0] value_in;
   logic                  valid_ff;
   logic                  valid_in;
   logic                  ins_here;
   logic                  rm_here;

   // first cell that takes the new value: first empty slot, or for an
   // ordered insert the first entry the value is greater than or equal to
   assign ins_here = !ins_in &&
                     (!valid_ff || (cmd.ordered && (cmd.value >= value_ff)));
   assign ins_out  = ins_in || ins_here;

   // first cell that drops out: the head, or the first equal entry
   assign rm_here = !rm_in && valid_ff && (cmd.head || (value_ff == cmd.value));
   assign rm_out  = rm_in || rm_here;

   always_comb begin
      value_in = value_ff;
      valid_in = valid_ff;
      case (cmd.op)
         OP_ADD: begin
            if (ins_in) begin
               value_in = left_value;
               valid_in = left_valid;
            end else if (ins_here) begin
               value_in = cmd.value;
               valid_in = 1'b1;
            end
         end
         OP_REMOVE: begin
            if (rm_out) begin
               value_in = right_value;
               valid_in = right_valid;
            end
         end
         OP_CLEAR: begin
            valid_in = 1'b0;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      value_ff <= value_in;
   end

   assign entry_value = value_ff;
   assign entry_valid = valid_ff;

endmodule

>>> hw/rtl/oeq_ctrl.sv
module oeq_ctrl
   import oeq_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  req_type               req_payload,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output rsp_type               rsp_payload,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic                  csr_data,
   input  logic [StoreWidth-1:0] cell_value [Capacity],
   input  logic [Capacity-1:0]   cell_valid,
   input  logic                  removed,
   output cell_cmd_type          cell_cmd
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_EXEC,
      ST_ERASE
   } state_type;

   state_type             state_ff;
   state_type             state_in;
   req_type               cmd_ff;
   req_type               cmd_in;
   logic [CountWidth-1:0] count_ff;
   logic [CountWidth-1:0] count_in;
   logic                  erased_ff;
   logic                  erased_in;
   logic                  ordering_ff;
   logic                  ordering_in;
   logic                  rsp_valid_ff;
   logic                  rsp_valid_in;
   rsp_type               rsp_payload_ff;
   rsp_type               rsp_payload_in;

   logic                  out_free;
   logic                  full;
   logic                  empty;
   logic                  value_nz;
   logic                  pos_hit;
   logic [StoreWidth-1:0] cmd_value;
   logic                  respond;
   logic                  res_ok;
   logic [31:0]           res_data;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign full      = (count_ff == CountWidth'(Capacity));
   assign empty     = (count_ff == '0);
   assign cmd_value = StoreWidth'(cmd_ff.value);
   assign value_nz  = (cmd_value != '0);
   assign pos_hit   = (32'(cmd_ff.position) < 32'(count_ff));

   assign ordering_in = csr_valid ? csr_data : ordering_ff;

   always_comb begin
      state_in     = state_ff;
      cmd_in       = cmd_ff;
      count_in     = count_ff;
      erased_in    = erased_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_payload_in = rsp_payload_ff;
      respond      = 1'b0;
      res_ok       = 1'b0;
      res_data     = '0;
      cell_cmd     = '{op: OP_HOLD, ordered: 1'b0, head: 1'b0, value: cmd_value};

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd_in   = req_payload;
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            if (out_free) begin
               respond  = 1'b1;
               state_in = ST_IDLE;
               unique case (cmd_ff.kind)
                  KindPush: begin
                     if (value_nz && !full) begin
                        cell_cmd.op = OP_ADD;
                        count_in    = count_ff + CountWidth'(1);
                        res_ok      = 1'b1;
                     end
                  end
                  KindPop: begin
                     if (!empty) begin
                        cell_cmd.op   = OP_REMOVE;
                        cell_cmd.head = 1'b1;
                        count_in      = count_ff - CountWidth'(1);
                        res_ok        = 1'b1;
                        res_data      = 32'(cell_value[0]);
                     end
                  end
                  KindInsert: begin
                     if (ordering_ff && !full && (!empty || value_nz)) begin
                        cell_cmd.op      = OP_ADD;
                        cell_cmd.ordered = 1'b1;
                        count_in         = count_ff + CountWidth'(1);
                        res_ok           = 1'b1;
                     end
                  end
                  KindErase: begin
                     if (ordering_ff && !empty) begin
                        respond   = 1'b0;
                        erased_in = 1'b0;
                        state_in  = ST_ERASE;
                     end
                  end
                  KindGet: begin
                     if (pos_hit) begin
                        res_ok   = 1'b1;
                        res_data = 32'(cell_value[IdxWidth'(cmd_ff.position)]);
                     end
                  end
                  KindClear: begin
                     cell_cmd.op = OP_CLEAR;
                     count_in    = '0;
                     res_ok      = 1'b1;
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_ERASE: begin
            // one matching entry leaves per cycle until none is left
            cell_cmd.op = OP_REMOVE;
            if (removed) begin
               count_in  = count_ff - CountWidth'(1);
               erased_in = 1'b1;
            end else if (out_free) begin
               respond  = 1'b1;
               res_ok   = erased_ff;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (respond) begin
         rsp_valid_in   = 1'b1;
         rsp_payload_in = '{ok: res_ok, data: res_data, count: 5'(count_in)};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         erased_ff    <= 1'b0;
         ordering_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         erased_ff    <= erased_in;
         ordering_ff  <= ordering_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      cmd_ff         <= cmd_in;
      rsp_payload_ff <= rsp_payload_in;
   end

   assign req_ready   = (state_ff == ST_IDLE);
   assign csr_ready   = 1'b1;
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

`ifndef SYNTHESIS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      32'(count_ff) <= Capacity)
      else $error("occupancy above capacity");

   a_count_cells: assert property (@(posedge clock) disable iff (reset)
      32'(count_ff) == $countones(cell_valid))
      else $error("occupancy disagrees with cell valid bits");

   a_clear_empties: assert property (@(posedge clock) disable iff (reset)
      (cell_cmd.op == OP_CLEAR) |=> (count_ff == '0) && (cell_valid == '0))
      else $error("clear left entries behind");

   a_erase_no_add: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_ERASE) |-> (cell_cmd.op == OP_REMOVE))
      else $error("erase issued a non-remove cell command");
`endif

endmodule

>>> dv/tb_ordered_entry_queue.sv
module tb_ordered_entry_queue;
   timeunit 1ns;
   timeprecision 1ps;

   import oeq_pkg::*;

   // the two kinds the block leaves unused
   localparam logic [2:0] KindUnusedLo = 3'd6;
   localparam logic [2:0] KindUnusedHi = 3'd7;

   // run limit that leaves plenty of margin over the worst case item
   localparam int CycleLimit = 500_000;
   // longest erase closes sixteen gaps, so let this many cycles pass at the end
   localparam int SettleCycles = 24;

   logic    clock       = 1'b0;
   logic    reset       = 1'b1;
   logic    req_valid   = 1'b0;
   logic    req_ready;
   req_type req_payload = '0;
   logic    rsp_valid;
   logic    rsp_ready   = 1'b0;
   rsp_type rsp_payload;
   logic    csr_valid   = 1'b0;
   logic    csr_ready;
   logic    csr_data    = 1'b0;

   // shadow of the queue contents, head at index 0
   logic [31:0] model_entries [Capacity];
   int unsigned model_count    = 0;
   logic        model_ordering = 1'b0;

   // replies still owed by the block, oldest first
   rsp_type     awaited_rsp [$];
   rsp_type     due_rsp;
   int unsigned fail_count  = 0;
   int unsigned items_sent  = 0;
   int unsigned cycle_count = 0;
   int unsigned stall_left  = 0;
   // random gaps on both channels while set
   logic        idling_on   = 1'b1;

   ordered_entry_queue DUT (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_data    (csr_data)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // run guard
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CycleLimit) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   // apply one item to the shadow queue and return the reply it must produce
   function automatic rsp_type model_queue_op(req_type r);
      rsp_type     e;
      int unsigned i;
      int unsigned w;
      e = '0;
      case (r.kind)
         KindPush: begin
            if (r.value != 0 && model_count < Capacity) begin
               model_entries[model_count] = r.value;
               model_count++;
               e.ok = 1'b1;
            end
         end
         KindPop: begin
            if (model_count > 0) begin
               e.data = model_entries[0];
               for (i = 1; i < model_count; i++)
                  model_entries[i - 1] = model_entries[i];
               model_count--;
               e.ok = 1'b1;
            end
         end
         KindInsert: begin
            if (model_ordering && model_count < Capacity) begin
               if (model_count == 0) begin
                  // empty queue: behaves as push, so null is refused
                  if (r.value != 0) begin
                     model_entries[0] = r.value;
                     model_count = 1;
                     e.ok = 1'b1;
                  end
               end else begin
                  // skip every entry strictly greater, then open a slot
                  i = 0;
                  while (i < model_count && r.value < model_entries[i])
                     i++;
                  for (w = model_count; w > i; w--)
                     model_entries[w] = model_entries[w - 1];
                  model_entries[i] = r.value;
                  model_count++;
                  e.ok = 1'b1;
               end
            end
         end
         KindErase: begin
            if (model_ordering && model_count > 0) begin
               // compact the survivors toward the head
               w = 0;
               for (i = 0; i < model_count; i++) begin
                  if (model_entries[i] == r.value) begin
                     e.ok = 1'b1;
                  end else begin
                     model_entries[w] = model_entries[i];
                     w++;
                  end
               end
               model_count = w;
            end
         end
         KindGet: begin
            if (r.position < model_count) begin
               e.data = model_entries[r.position];
               e.ok   = 1'b1;
            end
         end
         KindClear: begin
            model_count = 0;
            e.ok = 1'b1;
         end
         default: begin
         end
      endcase
      e.count = 5'(model_count);
      return e;
   endfunction

   function automatic req_type op_item(logic [2:0] kind, logic [31:0] value,
                                       logic [3:0] position);
      req_type r;
      r.kind     = kind;
      r.value    = value;
      r.position = position;
      return r;
   endfunction

   // biased toward extremes, small repeating values and values already stored
   function automatic logic [31:0] pick_value();
      logic [31:0] v;
      case ($urandom_range(0, 9))
         0:       v = '0;
         1:       v = '1;
         2, 3, 4: v = $urandom_range(1, 6);
         5:       v = (model_count > 0) ? model_entries[$urandom_range(0, model_count - 1)]
                                        : $urandom;
         default: v = $urandom;
      endcase
      return v;
   endfunction

   function automatic req_type random_item();
      int unsigned roll;
      int unsigned top;
      req_type     r;
      roll = $urandom_range(0, 99);
      // positions mostly near the occupied range, one past the tail included
      top = (model_count > 15) ? 15 : model_count;
      r.value    = pick_value();
      r.position = ($urandom_range(0, 3) == 0) ? 4'($urandom_range(0, 15))
                                                : 4'($urandom_range(0, top));
      if (roll < 24)      r.kind = KindPush;
      else if (roll < 40) r.kind = KindPop;
      else if (roll < 64) r.kind = KindInsert;
      else if (roll < 76) r.kind = KindErase;
      else if (roll < 90) r.kind = KindGet;
      else if (roll < 94) r.kind = KindClear;
      else                r.kind = roll[0] ? KindUnusedLo : KindUnusedHi;
      return r;
   endfunction

   // offer one item, optionally after an idle burst; valid stays up afterward
   task automatic send_item(req_type r);
      int unsigned gap;
      if (idling_on && $urandom_range(0, 4) == 0) begin
         req_valid <= 1'b0;
         gap = $urandom_range(1, 8);
         repeat (gap) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_payload <= r;
      do @(posedge clock); while (!req_ready);
      awaited_rsp.push_back(model_queue_op(r));
      items_sent++;
   endtask

   // stop offering and wait until every owed reply has come back
   task automatic hold_until_answered();
      req_valid <= 1'b0;
      do @(posedge clock); while (awaited_rsp.size() != 0);
   endtask

   // ordering_enabled only changes while the queue is quiet
   task automatic write_ordering(logic enable);
      hold_until_answered();
      csr_valid <= 1'b1;
      csr_data  <= enable;
      do @(posedge clock); while (!csr_ready);
      model_ordering = enable;
      csr_valid <= 1'b0;
   endtask

   // push or insert until full, then knock on the full queue
   task automatic fill_to_capacity();
      logic        uniform;
      logic [31:0] same_value;
      logic [2:0]  add_kind;
      // sometimes every entry added here is equal, so with ordering on the closing erase removes them all
      uniform    = ($urandom_range(0, 2) == 0);
      same_value = $urandom_range(1, 6);
      while (model_count < Capacity) begin
         add_kind = (model_ordering && $urandom_range(0, 1)) ? KindInsert : KindPush;
         send_item(op_item(add_kind, uniform ? same_value : pick_value(),
                           4'($urandom)));
      end
      send_item(op_item(KindPush, '1, 4'd0));
      send_item(op_item(KindInsert, same_value, 4'd0));
      send_item(op_item(KindGet, '0, 4'd15));
      send_item(op_item(KindErase, uniform ? same_value
                        : model_entries[$urandom_range(0, Capacity - 1)], 4'd0));
   endtask

   // ordering off: null push, empty queue, refused insert and erase, unused kinds
   task automatic test_directed_unordered();
      send_item(op_item(KindPush,     '0,           4'd0));
      send_item(op_item(KindPop,      '0,           4'd0));
      send_item(op_item(KindGet,      '0,           4'd0));
      send_item(op_item(KindErase,    '0,           4'd0));
      send_item(op_item(KindPush,     '1,           4'd0));
      send_item(op_item(KindPush,     32'd1,        4'd0));
      send_item(op_item(KindInsert,   32'd5,        4'd0));
      send_item(op_item(KindErase,    32'd1,        4'd0));
      send_item(op_item(KindUnusedLo, 32'd9,        4'd1));
      send_item(op_item(KindUnusedHi, '1,           4'd15));
      send_item(op_item(KindGet,      '0,           4'd1));
      send_item(op_item(KindGet,      '0,           4'd15));
      send_item(op_item(KindPop,      '0,           4'd0));
      send_item(op_item(KindClear,    '0,           4'd0));
   endtask

   // ordering on: null into empty, equal values, null into a filled queue, erase
   task automatic test_directed_ordered();
      write_ordering(1'b1);
      send_item(op_item(KindInsert, '0,    4'd0));
      send_item(op_item(KindErase,  32'd7, 4'd0));
      send_item(op_item(KindInsert, 32'd7, 4'd0));
      send_item(op_item(KindInsert, 32'd7, 4'd0));
      send_item(op_item(KindInsert, '1,    4'd0));
      send_item(op_item(KindInsert, '0,    4'd0));
      send_item(op_item(KindInsert, 32'd3, 4'd0));
      send_item(op_item(KindErase,  32'd7, 4'd0));
      send_item(op_item(KindErase,  32'd9, 4'd0));
      send_item(op_item(KindGet,    '0,    4'd0));
      send_item(op_item(KindPop,    '0,    4'd0));
      send_item(op_item(KindClear,  '0,    4'd0));
   endtask

   // random mix under one ordering setting, with an occasional run to full
   task automatic test_random_ops(logic enable, int unsigned n);
      int unsigned start;
      write_ordering(enable);
      start = items_sent;
      while (items_sent - start < n) begin
         if ($urandom_range(0, 59) == 0)
            fill_to_capacity();
         else
            send_item(random_item());
      end
   endtask

   // sender goes quiet mid-stream until the block has answered everything
   task automatic test_drain_pause();
      write_ordering(1'b1);
      repeat (40) send_item(random_item());
      hold_until_answered();
      repeat (40) send_item(random_item());
   endtask

   // reply side: random stall bursts, then compare each reply with the oldest owed
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready  <= 1'b0;
         stall_left = 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (awaited_rsp.size() == 0) begin
               $error("rsp item with none owed: ok %0d data %h count %0d",
                      rsp_payload.ok, rsp_payload.data, rsp_payload.count);
               fail_count++;
            end else begin
               due_rsp = awaited_rsp.pop_front();
               if (rsp_payload.ok !== due_rsp.ok) begin
                  $error("ok: expected %0d, got %0d", due_rsp.ok, rsp_payload.ok);
                  fail_count++;
               end
               if (rsp_payload.data !== due_rsp.data) begin
                  $error("data: expected %h, got %h", due_rsp.data, rsp_payload.data);
                  fail_count++;
               end
               if (rsp_payload.count !== due_rsp.count) begin
                  $error("count: expected %0d, got %0d", due_rsp.count,
                         rsp_payload.count);
                  fail_count++;
               end
            end
         end
         // stall bursts of random length, drawn when a burst starts
         if (stall_left != 0) begin
            rsp_ready <= 1'b0;
            stall_left--;
         end else if (idling_on && $urandom_range(0, 5) == 0) begin
            rsp_ready <= 1'b0;
            stall_left = $urandom_range(0, 7);
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed_unordered();
      test_directed_ordered();
      test_random_ops(1'b1, 300);
      test_random_ops(1'b0, 300);
      test_drain_pause();
      test_random_ops(1'b1, 300);
      test_random_ops(1'b0, 250);
      test_random_ops(1'b1, 300);
      // closing stretch runs back to back on both sides
      hold_until_answered();
      idling_on = 1'b0;
      test_random_ops(1'b1, 300);

      hold_until_answered();
      repeat (SettleCycles) @(posedge clock);
      if (fail_count == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

endmodule
